// ----- hw/rtl/positional_array_list_engine_unit_defines.svh -----
// Assertion macros for the positional array list engine.
`ifndef POSITIONAL_ARRAY_LIST_ENGINE_UNIT_DEFINES_SVH
`define POSITIONAL_ARRAY_LIST_ENGINE_UNIT_DEFINES_SVH

// Property that must hold at every clock edge out of reset.
`define PALE_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Property whose consequent must hold in the cycle after the antecedent.
`define PALE_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/pale_pkg.sv -----
// Shared codes and constants for the positional array list engine.
`timescale 1ns / 1ps
`default_nettype none
package pale_pkg;

    localparam int DATA_W = 32;

    localparam logic [2:0] MODE_APPEND   = 3'd0;
    localparam logic [2:0] MODE_INSERT   = 3'd1;
    localparam logic [2:0] MODE_DELETE   = 3'd2;
    localparam logic [2:0] MODE_REVERSE  = 3'd3;
    localparam logic [2:0] MODE_SORT     = 3'd4;
    localparam logic [2:0] MODE_READ_ALL = 3'd5;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_EMPTY  = 2'd2;
    localparam logic [1:0] ST_BADPOS = 2'd3;

    localparam logic [3:0] CAP_RESET = 4'd8;

endpackage
`default_nettype wire

// ----- hw/rtl/pale_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module pale_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        // hold read data while no read is issued
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/positional_array_list_engine_unit.sv -----
// Positional array list engine: list of signed words kept in a one-port-read RAM.
// Append writes the word straight into the store. Insert/delete move each shifted entry
// with a read and a write. Reverse swaps pairs with two reads and two writes. Sort is
// an exchange sort with a read and compare per inner step. Read all reads and sends each
// word in turn. The single RAM read port serializes all reads. One item at a time; next item enters once the last
// result sits in the output register. Reset empties the list and sets capacity to 8.
`timescale 1ns / 1ps
`default_nettype none
`include "positional_array_list_engine_unit_defines.svh"
module positional_array_list_engine_unit #(
    parameter int DEPTH = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [3:0]  cfg_wr_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [2:0]  mode,
    input  wire logic [31:0] value,
    input  wire logic [3:0]  position,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       status,
    output logic [31:0]      value_out,
    output logic [3:0]       count,
    output logic             last
);

    import pale_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = ((CW > 4) ? CW : 4) + 1;

    typedef enum logic [4:0] {
        S_IDLE, S_INS_RD, S_INS_WR, S_INS_PUT,
        S_DEL_CAP, S_DEL_SRD, S_DEL_SWR,
        S_REV_RDI, S_REV_RDJ, S_REV_WRI, S_REV_WRJ,
        S_SRT_RDI, S_SRT_CAPI, S_SRT_RDJ, S_SRT_CMP,
        S_RA_RD, S_RA_OUT, S_DONE
    } state_t;

    state_t              state_reg, state_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [3:0]          cap_reg, cap_next;
    logic [CW-1:0]       idx_reg, idx_next;
    logic [CW-1:0]       jdx_reg, jdx_next;
    logic [CW-1:0]       pidx_reg, pidx_next;
    logic [DATA_W-1:0]   val_reg, val_next;
    logic [DATA_W-1:0]   tmp_reg, tmp_next;
    logic [1:0]          st_reg, st_next;
    logic [DATA_W-1:0]   vout_reg, vout_next;
    logic                out_valid_reg, out_valid_next;
    logic [1:0]          status_reg, status_next;
    logic [DATA_W-1:0]   value_out_reg, value_out_next;
    logic [3:0]          count_reg, count_next;
    logic                last_reg, last_next;

    logic                mem_we, mem_re;
    logic [AW-1:0]       mem_waddr, mem_raddr;
    logic [DATA_W-1:0]   mem_wdata, mem_rdata;

    logic                in_fire, out_free, full;
    logic [XW-1:0]       cnt_x, cap_x, eff_cap, pos_x;

    pale_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_en   (mem_re),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;

    assign cnt_x   = XW'(cnt_reg);
    assign cap_x   = XW'(cap_reg);
    assign pos_x   = XW'(position);
    assign eff_cap = (cap_x > XW'(DEPTH)) ? XW'(DEPTH) : cap_x;
    assign full    = (cnt_x >= eff_cap);

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign value_out = value_out_reg;
    assign count     = count_reg;
    assign last      = last_reg;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        cap_next       = cfg_wr_en ? cfg_wr_data : cap_reg;
        idx_next       = idx_reg;
        jdx_next       = jdx_reg;
        pidx_next      = pidx_reg;
        val_next       = val_reg;
        tmp_next       = tmp_reg;
        st_next        = st_reg;
        vout_next      = vout_reg;
        out_valid_next = out_valid_reg && !out_ready;
        status_next    = status_reg;
        value_out_next = value_out_reg;
        count_next     = count_reg;
        last_next      = last_reg;
        mem_we         = 1'b0;
        mem_waddr      = idx_reg[AW-1:0];
        mem_wdata      = mem_rdata;
        mem_re         = 1'b0;
        mem_raddr      = idx_reg[AW-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    st_next    = ST_OK;
                    vout_next  = '0;
                    state_next = S_DONE;
                    case (mode)
                        MODE_APPEND:
                        begin
                            if (full)
                            begin
                                st_next = ST_FULL;
                            end
                            else
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = cnt_reg[AW-1:0];
                                mem_wdata = value;
                                cnt_next  = cnt_reg + CW'(1);
                            end
                        end
                        MODE_INSERT:
                        begin
                            if (full)
                            begin
                                st_next = ST_FULL;
                            end
                            else if (position == 4'd0 || pos_x > cnt_x + XW'(1))
                            begin
                                st_next = ST_BADPOS;
                            end
                            else
                            begin
                                val_next   = value;
                                pidx_next  = CW'(pos_x - XW'(1));
                                idx_next   = cnt_reg;
                                state_next = S_INS_RD;
                            end
                        end
                        MODE_DELETE:
                        begin
                            if (cnt_reg == '0)
                            begin
                                st_next = ST_EMPTY;
                            end
                            else if (position == 4'd0 || pos_x > cnt_x)
                            begin
                                st_next = ST_BADPOS;
                            end
                            else
                            begin
                                idx_next   = CW'(pos_x - XW'(1));
                                mem_re     = 1'b1;
                                mem_raddr  = idx_next[AW-1:0];
                                state_next = S_DEL_CAP;
                            end
                        end
                        MODE_REVERSE:
                        begin
                            if (cnt_reg > CW'(1))
                            begin
                                idx_next   = '0;
                                jdx_next   = cnt_reg - CW'(1);
                                state_next = S_REV_RDI;
                            end
                        end
                        MODE_SORT:
                        begin
                            idx_next   = '0;
                            state_next = S_SRT_RDI;
                        end
                        MODE_READ_ALL:
                        begin
                            if (cnt_reg == '0)
                            begin
                                st_next = ST_EMPTY;
                            end
                            else
                            begin
                                idx_next   = '0;
                                state_next = S_RA_RD;
                            end
                        end
                        default:
                        begin
                            st_next = ST_OK;
                        end
                    endcase
                end
            end

            // shift entries up from the tail down to the insert slot
            S_INS_RD:
            begin
                if (idx_reg > pidx_reg)
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = AW'(idx_reg - CW'(1));
                    state_next = S_INS_WR;
                end
                else
                begin
                    state_next = S_INS_PUT;
                end
            end
            S_INS_WR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = idx_reg[AW-1:0];
                mem_wdata  = mem_rdata;
                idx_next   = idx_reg - CW'(1);
                state_next = S_INS_RD;
            end
            S_INS_PUT:
            begin
                mem_we     = 1'b1;
                mem_waddr  = pidx_reg[AW-1:0];
                mem_wdata  = val_reg;
                cnt_next   = cnt_reg + CW'(1);
                state_next = S_DONE;
            end

            // capture the deleted word, then pull later entries down
            S_DEL_CAP:
            begin
                vout_next  = mem_rdata;
                state_next = S_DEL_SRD;
            end
            S_DEL_SRD:
            begin
                if (XW'(idx_reg) + XW'(1) < cnt_x)
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = AW'(idx_reg + CW'(1));
                    state_next = S_DEL_SWR;
                end
                else
                begin
                    cnt_next   = cnt_reg - CW'(1);
                    state_next = S_DONE;
                end
            end
            S_DEL_SWR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = idx_reg[AW-1:0];
                mem_wdata  = mem_rdata;
                idx_next   = idx_reg + CW'(1);
                state_next = S_DEL_SRD;
            end

            S_REV_RDI:
            begin
                if (idx_reg < jdx_reg)
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = idx_reg[AW-1:0];
                    state_next = S_REV_RDJ;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_REV_RDJ:
            begin
                tmp_next   = mem_rdata;
                mem_re     = 1'b1;
                mem_raddr  = jdx_reg[AW-1:0];
                state_next = S_REV_WRI;
            end
            S_REV_WRI:
            begin
                mem_we     = 1'b1;
                mem_waddr  = idx_reg[AW-1:0];
                mem_wdata  = mem_rdata;
                state_next = S_REV_WRJ;
            end
            S_REV_WRJ:
            begin
                mem_we     = 1'b1;
                mem_waddr  = jdx_reg[AW-1:0];
                mem_wdata  = tmp_reg;
                idx_next   = idx_reg + CW'(1);
                jdx_next   = jdx_reg - CW'(1);
                state_next = S_REV_RDI;
            end

            // exchange sort: hold entry i in tmp_reg, write back after the inner pass
            S_SRT_RDI:
            begin
                if (idx_reg < cnt_reg)
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = idx_reg[AW-1:0];
                    jdx_next   = idx_reg + CW'(1);
                    state_next = S_SRT_CAPI;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_SRT_CAPI:
            begin
                tmp_next   = mem_rdata;
                state_next = S_SRT_RDJ;
            end
            S_SRT_RDJ:
            begin
                if (jdx_reg < cnt_reg)
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = jdx_reg[AW-1:0];
                    state_next = S_SRT_CMP;
                end
                else
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = idx_reg[AW-1:0];
                    mem_wdata  = tmp_reg;
                    idx_next   = idx_reg + CW'(1);
                    state_next = S_SRT_RDI;
                end
            end
            S_SRT_CMP:
            begin
                if ($signed(tmp_reg) > $signed(mem_rdata))
                begin
                    mem_we    = 1'b1;
                    mem_waddr = jdx_reg[AW-1:0];
                    mem_wdata = tmp_reg;
                    tmp_next  = mem_rdata;
                end
                jdx_next   = jdx_reg + CW'(1);
                state_next = S_SRT_RDJ;
            end

            S_RA_RD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = idx_reg[AW-1:0];
                state_next = S_RA_OUT;
            end
            S_RA_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = ST_OK;
                    value_out_next = mem_rdata;
                    count_next     = cnt_x[3:0];
                    last_next      = (idx_reg + CW'(1) == cnt_reg);
                    idx_next       = idx_reg + CW'(1);
                    state_next     = (idx_reg + CW'(1) == cnt_reg) ? S_IDLE : S_RA_RD;
                end
            end

            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = st_reg;
                    value_out_next = vout_reg;
                    count_next     = cnt_x[3:0];
                    last_next      = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            cap_reg       <= CAP_RESET;
            idx_reg       <= '0;
            jdx_reg       <= '0;
            pidx_reg      <= '0;
            val_reg       <= '0;
            tmp_reg       <= '0;
            st_reg        <= ST_OK;
            vout_reg      <= '0;
            out_valid_reg <= 1'b0;
            status_reg    <= ST_OK;
            value_out_reg <= '0;
            count_reg     <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            cap_reg       <= cap_next;
            idx_reg       <= idx_next;
            jdx_reg       <= jdx_next;
            pidx_reg      <= pidx_next;
            val_reg       <= val_next;
            tmp_reg       <= tmp_next;
            st_reg        <= st_next;
            vout_reg      <= vout_next;
            out_valid_reg <= out_valid_next;
            status_reg    <= status_next;
            value_out_reg <= value_out_next;
            count_reg     <= count_next;
            last_reg      <= last_next;
        end
    end

    `PALE_ALWAYS(a_count_bound, XW'(cnt_reg) <= XW'(DEPTH), "entry count exceeds store depth")

    `PALE_ALWAYS(a_partial_only_read_all, !(out_valid_reg && !last_reg) || state_reg == S_RA_RD || state_reg == S_RA_OUT || state_reg == S_IDLE, "non-final word outside read all")

    `PALE_NEXT(a_append_grows, in_fire && mode == MODE_APPEND && !full, cnt_reg == $past(cnt_reg) + CW'(1), "append did not grow the list")

endmodule
`default_nettype wire
